/* src/sot_pkg.sv */
// Shared types and codes for the segment offset table.
// Holds the request and result item structs, action codes and status codes.
// No dependencies.
package sot_pkg;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;
    localparam logic [1:0] STATUS_ZERO  = 2'd3;

    typedef struct packed {
        logic        action;
        logic [15:0] type_id;
        logic [15:0] elem_count;
        logic [15:0] slot_index;
    } request_t;

    typedef struct packed {
        logic [15:0] start_offset;
        logic [15:0] found_type;
        logic [1:0]  status;
    } result_t;

endpackage

/* src/sot_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/sot_step.sv */
// One binary search step: compares a stored start offset against the key,
// narrows the bounds and picks the next table address to read.
// No package dependencies.
module sot_step #(
    parameter int OFS_W  = 16,
    parameter int IDX_W  = 7,
    parameter int ADDR_W = 6
) (
    input  logic              first,
    input  logic [IDX_W-1:0]  lo,
    input  logic [IDX_W-1:0]  hi,
    input  logic [ADDR_W-1:0] mid,
    input  logic [15:0]       key,
    input  logic [OFS_W-1:0]  entry_start,
    output logic [IDX_W-1:0]  lo_next,
    output logic [IDX_W-1:0]  hi_next,
    output logic              more,
    output logic [ADDR_W-1:0] addr
);

    localparam int CMP_W = (OFS_W > 16) ? OFS_W : 16;

    logic             pass;
    logic [IDX_W-1:0] mid_ext;
    logic [IDX_W-1:0] span;
    logic [IDX_W-1:0] probe;

    always_comb
    begin
        mid_ext = IDX_W'(mid);
        pass    = CMP_W'(entry_start) <= CMP_W'(key);
        if (first)
        begin
            lo_next = lo;
            hi_next = hi;
        end
        else if (pass)
        begin
            lo_next = mid_ext;
            hi_next = hi;
        end
        else
        begin
            lo_next = lo;
            hi_next = mid_ext;
        end
        span  = hi_next - lo_next;
        more  = span > IDX_W'(1);
        // With the range settled, the last read fetches the lower bound itself.
        probe = more ? (lo_next + (span >> 1)) : lo_next;
        addr  = probe[ADDR_W-1:0];
    end

endmodule

/* src/segment_offset_table.sv */
// Top level of the segment offset table.
// Depends on sot_pkg, sot_ram and sot_step.

// An append item is checked and written in the cycle it is accepted; its result
// strobes on done in the next cycle and busy stays low, so appends run one per
// cycle. A lookup that is out of range answers the same way. A lookup in range
// runs a binary search, one table read and one compare per cycle through the
// RAM's registered read port, then a fetch state reads the chosen entry, with
// busy high until the result strobes. The receiver cannot stall: every result
// strobes on done for a single cycle and stays on the result port until the next.
module segment_offset_table #(
    parameter int MAX_SEGMENTS = 64,
    parameter int SLOT_SPACE   = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sot_pkg::request_t request,
    output logic              busy,
    output logic              done,
    output sot_pkg::result_t  result
);

    import sot_pkg::*;

    localparam int OFS_W  = $clog2(SLOT_SPACE);
    localparam int NF_W   = OFS_W + 1;
    localparam int IDX_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int ADDR_W = $clog2(MAX_SEGMENTS);
    localparam int CMP_W  = (NF_W > 16) ? NF_W : 16;
    localparam int SUM_W  = CMP_W + 1;
    localparam int RAM_W  = OFS_W + 16;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_FETCH  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  seg_used_reg, seg_used_next;
    logic [NF_W-1:0]   next_free_reg, next_free_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [ADDR_W-1:0] mid_reg, mid_next;
    logic [15:0]       key_reg, key_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic              accept;
    logic              step_first;
    logic [IDX_W-1:0]  step_lo, step_hi, step_lo_next, step_hi_next;
    logic [15:0]       step_key;
    logic              step_more;
    logic [ADDR_W-1:0] step_addr;

    logic              ram_we;
    logic [RAM_W-1:0]  ram_wdata, ram_rdata;
    logic [OFS_W-1:0]  entry_start;
    logic [15:0]       entry_type;

    logic [CMP_W-1:0]  nf_ext;
    logic [SUM_W-1:0]  nf_sum;
    logic              is_full;
    logic              is_over;
    logic              out_of_range;

    assign accept      = start && (state_reg == S_IDLE);
    assign busy        = state_reg != S_IDLE;
    assign done        = done_reg;
    assign result      = result_reg;
    assign entry_start = ram_rdata[OFS_W-1:0];
    assign entry_type  = ram_rdata[RAM_W-1:OFS_W];

    assign nf_ext       = CMP_W'(next_free_reg);
    assign nf_sum       = SUM_W'(nf_ext) + SUM_W'(request.elem_count);
    assign is_full      = seg_used_reg == IDX_W'(MAX_SEGMENTS);
    assign is_over      = nf_sum > SUM_W'(SLOT_SPACE);
    assign out_of_range = (seg_used_reg == '0)
                          || (CMP_W'(request.slot_index) >= nf_ext);

    // In idle the step unit only sizes the first probe from the full range.
    assign step_first = state_reg == S_IDLE;
    assign step_lo    = step_first ? '0 : lo_reg;
    assign step_hi    = step_first ? seg_used_reg : hi_reg;
    assign step_key   = step_first ? request.slot_index : key_reg;

    sot_step #(
        .OFS_W  (OFS_W),
        .IDX_W  (IDX_W),
        .ADDR_W (ADDR_W)
    ) u_step (
        .first       (step_first),
        .lo          (step_lo),
        .hi          (step_hi),
        .mid         (mid_reg),
        .key         (step_key),
        .entry_start (entry_start),
        .lo_next     (step_lo_next),
        .hi_next     (step_hi_next),
        .more        (step_more),
        .addr        (step_addr)
    );

    assign ram_wdata = {request.type_id, next_free_reg[OFS_W-1:0]};

    sot_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (seg_used_reg[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .raddr (step_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        seg_used_next  = seg_used_reg;
        next_free_next = next_free_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        ram_we         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next.start_offset = '0;
                    result_next.found_type   = '0;
                    result_next.status       = STATUS_OK;
                    if (request.action == ACT_APPEND)
                    begin
                        done_next = 1'b1;
                        if (request.elem_count == '0)
                        begin
                            result_next.status = STATUS_ZERO;
                        end
                        else if (is_full || is_over)
                        begin
                            result_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            ram_we                   = 1'b1;
                            seg_used_next            = seg_used_reg + IDX_W'(1);
                            next_free_next           = nf_sum[NF_W-1:0];
                            result_next.start_offset = nf_ext[15:0];
                        end
                    end
                    else if (out_of_range)
                    begin
                        done_next          = 1'b1;
                        result_next.status = STATUS_RANGE;
                    end
                    else
                    begin
                        lo_next    = step_lo_next;
                        hi_next    = step_hi_next;
                        mid_next   = step_addr;
                        key_next   = request.slot_index;
                        state_next = step_more ? S_SEARCH : S_FETCH;
                    end
                end
            end
            S_SEARCH:
            begin
                lo_next    = step_lo_next;
                hi_next    = step_hi_next;
                mid_next   = step_addr;
                state_next = step_more ? S_SEARCH : S_FETCH;
            end
            S_FETCH:
            begin
                done_next              = 1'b1;
                result_next.found_type = entry_type;
                state_next             = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seg_used_reg  <= '0;
            next_free_reg <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            key_reg       <= '0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_used_reg  <= seg_used_next;
            next_free_reg <= next_free_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            key_reg       <= key_next;
            done_reg      <= done_next;
            result_reg    <= result_next;
        end
    end

`ifndef ASSERT_OFF
    a_fetch_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |=> (done_reg && (state_reg == S_IDLE)))
        else $error("lookup fetch did not deliver its result");

    a_search_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> ((hi_reg - lo_reg) > IDX_W'(1)))
        else $error("search running on a settled range");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seg_used_reg <= IDX_W'(MAX_SEGMENTS))
        else $error("segment count past table depth");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(next_free_reg) <= CMP_W'(SLOT_SPACE))
        else $error("next free offset past slot space");

    a_append_free: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.action == ACT_APPEND)) |=> (state_reg == S_IDLE))
        else $error("append left the block busy");
`endif

endmodule

/* tb/sv/segment_offset_table_test.sv */
// Self-checking testbench for the segment offset table: directed and random appends and lookups.
// A scoreboard class predicts each result from its own copy of the table and checks it.
// Depends on sot_pkg and segment_offset_table.
module segment_offset_table_test;
    import sot_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int SPACE_SIZE  = 65536;

    // Shadow of the segment table. It predicts each result when an item is accepted
    // and checks results in order.
    class segment_scoreboard;
        logic [15:0] seg_base [TABLE_DEPTH];
        logic [15:0] seg_kind [TABLE_DEPTH];
        int unsigned used;
        int unsigned next_off;
        result_t     expected_results [$];
        int          mismatch_count;

        function new();
            used = 0;
            next_off = 0;
            mismatch_count = 0;
        endfunction

        function void note_request(request_t item);
            result_t     res;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            res = '0;
            res.status = STATUS_OK;
            if (item.action == ACT_APPEND)
            begin
                // A zero count is rejected before the table and space limits are checked.
                if (item.elem_count == 16'd0)
                begin
                    res.status = STATUS_ZERO;
                end
                else if (used >= TABLE_DEPTH)
                begin
                    res.status = STATUS_FULL;
                end
                else if (next_off + 32'(item.elem_count) > SPACE_SIZE)
                begin
                    res.status = STATUS_FULL;
                end
                else
                begin
                    seg_base[used] = next_off[15:0];
                    seg_kind[used] = item.type_id;
                    res.start_offset = next_off[15:0];
                    used++;
                    next_off += 32'(item.elem_count);
                end
            end
            else if (used == 0 || 32'(item.slot_index) >= next_off)
            begin
                res.status = STATUS_RANGE;
            end
            else
            begin
                // Find the last segment whose base is at or below the index.
                lo = 0;
                hi = used;
                while (hi - lo > 1)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (seg_base[mid] <= item.slot_index)
                        lo = mid;
                    else
                        hi = mid;
                end
                res.found_type = seg_kind[lo];
            end
            expected_results.insert(expected_results.size(), res);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result offset %h type %h status %0d", $time,
                         got.start_offset, got.found_type, got.status);
                mismatch_count++;
                return;
            end
            exp = expected_results.pop_front();
            if (got.start_offset !== exp.start_offset)
            begin
                $display("%0t: start_offset expected %h actual %h", $time,
                         exp.start_offset, got.start_offset);
                mismatch_count++;
            end
            if (got.found_type !== exp.found_type)
            begin
                $display("%0t: found_type expected %h actual %h", $time,
                         exp.found_type, got.found_type);
                mismatch_count++;
            end
            if (got.status !== exp.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
                mismatch_count++;
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    request_t request;
    logic     busy;
    logic     done;
    result_t  result;

    segment_scoreboard board;

    segment_offset_table #(
        .MAX_SEGMENTS(TABLE_DEPTH),
        .SLOT_SPACE  (SPACE_SIZE)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(result);
    end

    function automatic request_t make_item(logic act, logic [15:0] tid, logic [15:0] cnt,
                                           logic [15:0] slot);
        request_t item;
        item.action = act;
        item.type_id = tid;
        item.elem_count = cnt;
        item.slot_index = slot;
        return item;
    endfunction

    // Holds the item on the bus until the block takes it. Start stays high afterward.
    task automatic send_item(input request_t item);
        start <= 1'b1;
        request <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(item);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (board.expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int count);
        request_t    item;
        int unsigned k;
        int unsigned base;
        int unsigned lim;
        for (int n = 0; n < count; n++)
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            item = make_item(ACT_LOOKUP, 16'($urandom_range(65535)),
                             16'($urandom_range(65535)), 16'($urandom_range(65535)));
            if ($urandom_range(6) == 0)
            begin
                item.action = ACT_APPEND;
                case ($urandom_range(9))
                    0: item.elem_count = 16'd0;
                    1: item.elem_count = 16'($urandom_range(65535));
                    default:
                        // Closing the last free segment exactly at the end of the slot space.
                        if (board.used == TABLE_DEPTH - 1 && board.next_off < SPACE_SIZE
                            && $urandom_range(1) == 0)
                            item.elem_count = 16'(SPACE_SIZE - board.next_off);
                        else
                            item.elem_count = 16'($urandom_range(400, 1));
                endcase
            end
            else if (board.used != 0)
            begin
                case ($urandom_range(7))
                    0: ;
                    1: item.slot_index = (board.next_off >= SPACE_SIZE) ? 16'hFFFF
                                                                        : 16'(board.next_off);
                    2: item.slot_index = 16'(board.next_off - 1);
                    default:
                    begin
                        k = $urandom_range(board.used - 1);
                        base = 32'(board.seg_base[k]);
                        lim = (k + 1 < board.used) ? 32'(board.seg_base[k + 1])
                                                   : board.next_off;
                        case ($urandom_range(2))
                            0: item.slot_index = 16'(base);
                            1: item.slot_index = 16'(lim - 1);
                            default: item.slot_index = 16'(base + $urandom_range(lim - base - 1));
                        endcase
                    end
                endcase
            end
            send_item(item);
        end
        wait_idle();
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, zero count, single slots, space overflow and segment boundaries.
        send_item(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(ACT_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_item(ACT_APPEND, 16'h1234, 16'h0000, 16'h0000));
        send_item(make_item(ACT_APPEND, 16'hFFFF, 16'h0001, 16'hFFFF));
        send_item(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0001));
        send_item(make_item(ACT_APPEND, 16'h0000, 16'h0002, 16'h0000));
        send_item(make_item(ACT_APPEND, 16'hABCD, 16'hFFFF, 16'h0000));
        send_item(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0002));
        send_item(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0003));
        send_item(make_item(ACT_APPEND, 16'h5555, 16'h00FF, 16'h0000));
        send_item(make_item(ACT_APPEND, 16'hAAAA, 16'hFF00, 16'h0000));
        send_item(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'd257));
        send_item(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0001));
        send_item(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h8000));
        send_item(make_item(ACT_APPEND, 16'h7FFF, 16'h8000, 16'h0000));
        send_item(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h8000));
        send_item(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'd258));
        send_item(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'd257));
        wait_idle();

        run_phase(0, 300);
        run_phase(77, 300);
        run_phase(7, 300);

        // Make sure the table ends full and the slot space exactly used up.
        while (board.used < TABLE_DEPTH - 1 && board.next_off < SPACE_SIZE - 1)
            send_item(make_item(ACT_APPEND, 16'($urandom_range(65535)), 16'h0001, 16'h0000));
        if (board.used == TABLE_DEPTH - 1 && board.next_off < SPACE_SIZE)
            send_item(make_item(ACT_APPEND, 16'($urandom_range(65535)),
                                16'(SPACE_SIZE - board.next_off), 16'h0000));
        send_item(make_item(ACT_APPEND, 16'h4321, 16'h0001, 16'h0000));
        send_item(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'hFFFF));
        send_item(make_item(ACT_LOOKUP, 16'h0000, 16'h0000, 16'h0000));
        wait_idle();
        repeat (16) @(posedge clk);

        if (board.mismatch_count == 0 && board.expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("status: fail");
        $finish;
    end

endmodule
